// ===== design/tcfbs_pkg.sv =====
// Shared constants and types for the three-class FIFO burst server.
// No dependencies; every other design file refers to it by scoped names.
package tcfbs_pkg;

   localparam int QUEUE_DEPTH = 16;
   localparam int MAX_SERVE   = 64;
   localparam int NUM_CLASSES = 3;

   localparam int TAG_W   = 64;
   localparam int CLASS_W = 2;
   localparam int SERVE_W = 7;
   localparam int CNT_W   = $clog2(MAX_SERVE + 1);
   localparam int SEL_W   = $clog2(NUM_CLASSES);

   typedef enum logic [0:0] {
      REQ_ENQUEUE = 1'b0,
      REQ_SERVE   = 1'b1
   } req_kind_type;

   localparam logic [CLASS_W-1:0] CLASS_FIRST  = 2'd0;
   localparam logic [CLASS_W-1:0] CLASS_SECOND = 2'd1;
   localparam logic [CLASS_W-1:0] CLASS_THIRD  = 2'd2;
   localparam logic [CLASS_W-1:0] CLASS_OTHER  = 2'd3;

   typedef enum logic [0:0] {
      ST_IDLE  = 1'b0,
      ST_SERVE = 1'b1
   } state_type;

   // one queue slot as seen by its neighbours
   typedef struct packed {
      logic             valid;
      logic [TAG_W-1:0] tag;
   } cell_data_type;

   // per-cycle control broadcast along a chain
   typedef struct packed {
      logic shift;
      logic load;
   } cell_ctrl_type;

endpackage

// ===== design/tcfbs_if.sv =====
// Valid/ready channel interfaces for requests and responses.
// Depends on tcfbs_pkg for field widths.
interface tcfbs_req_if;
   logic                          valid;
   logic                          ready;
   logic                          req_type;
   logic [tcfbs_pkg::CLASS_W-1:0] queue_class;
   logic [tcfbs_pkg::TAG_W-1:0]   customer_tag;
   logic [tcfbs_pkg::SERVE_W-1:0] serve_count;

   modport source (output valid, req_type, queue_class, customer_tag, serve_count,
                   input ready);
   modport sink   (input valid, req_type, queue_class, customer_tag, serve_count,
                   output ready);
endinterface

interface tcfbs_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [tcfbs_pkg::CLASS_W-1:0] served_class;
   logic [tcfbs_pkg::TAG_W-1:0]   served_tag;
   logic                          was_empty;
   logic                          last_result;

   modport source (output valid, served_class, served_tag, was_empty, last_result,
                   input ready);
   modport sink   (input valid, served_class, served_tag, was_empty, last_result,
                   output ready);
endinterface

// ===== design/tcfbs_cell.sv =====
// One slot of a class queue: holds a tag and its occupancy bit.
// Depends on tcfbs_pkg for the slot and control structs.
module tcfbs_cell (
   input  logic                     clock,
   input  logic                     reset,
   input  tcfbs_pkg::cell_ctrl_type ctrl,
   input  logic [tcfbs_pkg::TAG_W-1:0] in_tag,
   input  logic                     prev_valid,
   input  tcfbs_pkg::cell_data_type next,
   output tcfbs_pkg::cell_data_type out
);

   logic                        valid_ff, valid_in;
   logic [tcfbs_pkg::TAG_W-1:0] tag_ff, tag_in;

   // pop moves everything one slot towards the head; a push lands in the
   // first empty slot, i.e. the one whose predecessor is occupied
   always_comb begin
      priority if (ctrl.shift) begin
         valid_in = next.valid;
         tag_in   = next.tag;
      end else if (ctrl.load && !valid_ff && prev_valid) begin
         valid_in = 1'b1;
         tag_in   = in_tag;
      end else begin
         valid_in = valid_ff;
         tag_in   = tag_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      tag_ff <= tag_in;
   end

   assign out.valid = valid_ff;
   assign out.tag   = tag_ff;

endmodule

// ===== design/tcfbs_queue.sv =====
// One class queue built as a row of tcfbs_cell slots, head at slot 0.
// Depends on tcfbs_pkg and tcfbs_cell.
module tcfbs_queue (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        push,
   input  logic                        pop,
   input  logic [tcfbs_pkg::TAG_W-1:0] push_tag,
   output tcfbs_pkg::cell_data_type    head
);

   localparam tcfbs_pkg::cell_data_type EMPTY_SLOT = '0;

   tcfbs_pkg::cell_data_type slot [tcfbs_pkg::QUEUE_DEPTH];
   tcfbs_pkg::cell_ctrl_type ctrl;

   assign ctrl.shift = pop;
   assign ctrl.load  = push;

   for (genvar i = 0; i < tcfbs_pkg::QUEUE_DEPTH; i++) begin : g_cell
      logic                     prev_valid;
      tcfbs_pkg::cell_data_type next;

      if (i == 0) begin : g_first
         assign prev_valid = 1'b1;
      end else begin : g_mid
         assign prev_valid = slot[i-1].valid;
      end

      if (i == tcfbs_pkg::QUEUE_DEPTH - 1) begin : g_last
         assign next = EMPTY_SLOT;
      end else begin : g_inner
         assign next = slot[i+1];
      end

      tcfbs_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctrl       (ctrl),
         .in_tag     (push_tag),
         .prev_valid (prev_valid),
         .next       (next),
         .out        (slot[i])
      );
   end

   assign head = slot[0];

endmodule

// ===== design/three_class_fifo_burst_server_unit.sv =====
// Three-class FIFO burst server: top level with request sequencer.
// Depends on tcfbs_pkg, tcfbs_if and tcfbs_queue.
//
// Usage:
//   req channel: one transaction per request. req_type 0 enqueues
//   customer_tag on queue_class (class 3 goes to the third queue); a full
//   queue drops the tag silently. req_type 1 serves serve_count dequeues
//   (saturated at MAX_SERVE) from queue_class; class 3 or a zero count
//   does nothing.
//   rsp channel: one transaction per dequeue, carrying the head tag or an
//   empty marker (was_empty set, tag zero); last_result marks the end of
//   the burst.
//   Throughput: an enqueue leaves req.ready high. A serve of N holds req.ready
//   low while the burst walks the head of the chosen cell chain, one dequeue
//   per cycle unless the output register is stalled; the serve is registered
//   in the state register before the first response enters the output register.
//   Reset clears all queues and the output register at once; there is no
//   clearing pass. If the receiver stalls, the output register holds its
//   response and the burst waits, so req.ready stays low until the burst
//   has been fully handed to the output register.
module three_class_fifo_burst_server_unit (
   input  logic        clock,
   input  logic        reset,
   tcfbs_req_if.sink   req,
   tcfbs_rsp_if.source rsp
);

   tcfbs_pkg::state_type state_ff, state_in;
   logic [tcfbs_pkg::CLASS_W-1:0] cls_ff, cls_in;
   logic [tcfbs_pkg::CNT_W-1:0]   left_ff, left_in;

   logic                          rsp_valid_ff, rsp_valid_in;
   logic [tcfbs_pkg::CLASS_W-1:0] rsp_class_ff, rsp_class_in;
   logic [tcfbs_pkg::TAG_W-1:0]   rsp_tag_ff, rsp_tag_in;
   logic                          rsp_empty_ff, rsp_empty_in;
   logic                          rsp_last_ff, rsp_last_in;

   logic accept, is_serve, serve_start, step, last_step;
   logic [tcfbs_pkg::CLASS_W-1:0] enq_class;
   logic [tcfbs_pkg::CNT_W-1:0]   sat_count;
   logic [tcfbs_pkg::SEL_W-1:0]   sel;

   tcfbs_pkg::cell_data_type      heads [tcfbs_pkg::NUM_CLASSES];
   tcfbs_pkg::cell_data_type      cur_head;
   logic [tcfbs_pkg::NUM_CLASSES-1:0] push, pop;

   assign accept    = req.valid && req.ready;
   assign is_serve  = (req.req_type == tcfbs_pkg::REQ_SERVE);
   assign enq_class = (req.queue_class == tcfbs_pkg::CLASS_OTHER) ?
                      tcfbs_pkg::CLASS_THIRD : req.queue_class;
   assign sat_count = (req.serve_count > tcfbs_pkg::SERVE_W'(tcfbs_pkg::MAX_SERVE)) ?
                      tcfbs_pkg::CNT_W'(tcfbs_pkg::MAX_SERVE) :
                      tcfbs_pkg::CNT_W'(req.serve_count);
   assign serve_start = accept && is_serve &&
                        (req.queue_class != tcfbs_pkg::CLASS_OTHER) &&
                        (req.serve_count != '0);

   assign sel       = tcfbs_pkg::SEL_W'(cls_ff);
   assign cur_head  = heads[sel];
   assign last_step = (left_ff == tcfbs_pkg::CNT_W'(1));

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         tcfbs_pkg::ST_IDLE: begin
            if (serve_start) state_in = tcfbs_pkg::ST_SERVE;
         end
         tcfbs_pkg::ST_SERVE: begin
            if (step && last_step) state_in = tcfbs_pkg::ST_IDLE;
         end
         default: state_in = tcfbs_pkg::ST_IDLE;
      endcase
   end

   // state outputs
   always_comb begin
      req.ready = 1'b0;
      step      = 1'b0;
      unique case (state_ff)
         tcfbs_pkg::ST_IDLE:  req.ready = 1'b1;
         tcfbs_pkg::ST_SERVE: step = !rsp_valid_ff || rsp.ready;
         default: ;
      endcase
   end

   always_comb begin
      cls_in  = cls_ff;
      left_in = left_ff;
      if (serve_start) begin
         cls_in  = req.queue_class;
         left_in = sat_count;
      end else if (step) begin
         left_in = left_ff - tcfbs_pkg::CNT_W'(1);
      end
   end

   for (genvar c = 0; c < tcfbs_pkg::NUM_CLASSES; c++) begin : g_queue
      assign push[c] = accept && !is_serve && (enq_class == tcfbs_pkg::CLASS_W'(c));
      assign pop[c]  = step && (cls_ff == tcfbs_pkg::CLASS_W'(c)) && heads[c].valid;

      tcfbs_queue u_queue (
         .clock    (clock),
         .reset    (reset),
         .push     (push[c]),
         .pop      (pop[c]),
         .push_tag (req.customer_tag),
         .head     (heads[c])
      );
   end

   // output register: loaded on every dequeue step, cleared once taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      rsp_class_in = rsp_class_ff;
      rsp_tag_in   = rsp_tag_ff;
      rsp_empty_in = rsp_empty_ff;
      rsp_last_in  = rsp_last_ff;
      if (step) begin
         rsp_valid_in = 1'b1;
         rsp_class_in = cls_ff;
         rsp_tag_in   = cur_head.valid ? cur_head.tag : '0;
         rsp_empty_in = !cur_head.valid;
         rsp_last_in  = last_step;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= tcfbs_pkg::ST_IDLE;
         left_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         left_ff      <= left_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cls_ff       <= cls_in;
      rsp_class_ff <= rsp_class_in;
      rsp_tag_ff   <= rsp_tag_in;
      rsp_empty_ff <= rsp_empty_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign rsp.valid        = rsp_valid_ff;
   assign rsp.served_class = rsp_class_ff;
   assign rsp.served_tag   = rsp_tag_ff;
   assign rsp.was_empty    = rsp_empty_ff;
   assign rsp.last_result  = rsp_last_ff;

endmodule

// ===== design/tcfbs_checker.sv =====
// Port-level checks for the three-class FIFO burst server, bound to the top.
// Depends on tcfbs_pkg and the top level's interface ports.
module tcfbs_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_ready,
   input logic                          req_type,
   input logic [tcfbs_pkg::CLASS_W-1:0] req_class,
   input logic [tcfbs_pkg::SERVE_W-1:0] req_count,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic [tcfbs_pkg::CLASS_W-1:0] rsp_class,
   input logic [tcfbs_pkg::TAG_W-1:0]   rsp_tag,
   input logic                          rsp_empty
);

   // a stalled response holds its tag
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_tag))
      else $error("response changed while stalled");

   // empty marker always carries a zero tag
   a_empty_tag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_empty |-> rsp_tag == '0)
      else $error("empty marker with nonzero tag");

   // responses never name the catch-all class
   a_rsp_class: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_class != tcfbs_pkg::CLASS_OTHER)
      else $error("response from catch-all class");

   // a real serve blocks new requests while its burst runs
   a_serve_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (req_type == tcfbs_pkg::REQ_SERVE) &&
      (req_class != tcfbs_pkg::CLASS_OTHER) && (req_count != '0) |=> !req_ready)
      else $error("request taken during serve burst");

   // reset leaves no response pending
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

endmodule

bind three_class_fifo_burst_server_unit tcfbs_checker u_tcfbs_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req.valid),
   .req_ready (req.ready),
   .req_type  (req.req_type),
   .req_class (req.queue_class),
   .req_count (req.serve_count),
   .rsp_valid (rsp.valid),
   .rsp_ready (rsp.ready),
   .rsp_class (rsp.served_class),
   .rsp_tag   (rsp.served_tag),
   .rsp_empty (rsp.was_empty)
);

// ===== tb/sv/tb_three_class_fifo_burst_server_unit.sv =====
// Testbench for the three-class FIFO burst server: directed and random enqueue/serve traffic.
// Depends on tcfbs_pkg, tcfbs_if and three_class_fifo_burst_server_unit; a local queue model
// predicts every served transaction and the monitor checks each one in order.
module tb_three_class_fifo_burst_server_unit;
   timeunit 1ns;
   timeprecision 1ps;

   import tcfbs_pkg::*;

   localparam int CYCLE_LIMIT = 400000;
   localparam int REQ_TARGET  = 250;
   localparam int TAIL_ITEMS  = 30;
   localparam int SETTLE_CYC  = 80;

   typedef struct {
      req_kind_type         kind;
      logic [CLASS_W-1:0]   cls;
      logic [TAG_W-1:0]     tag;
      logic [SERVE_W-1:0]   count;
      bit                   drain_first;
   } burst_req_t;

   typedef struct {
      logic [CLASS_W-1:0] cls;
      logic [TAG_W-1:0]   tag;
      logic               empty;
      logic               last;
   } served_item_t;

   logic clock;
   logic reset;

   tcfbs_req_if req_chan ();
   tcfbs_rsp_if rsp_chan ();

   three_class_fifo_burst_server_unit dut (
      .clock (clock),
      .reset (reset),
      .req   (req_chan.sink),
      .rsp   (rsp_chan.source)
   );

   // stimulus and scoreboard storage
   burst_req_t   pending_reqs[$];
   served_item_t served_expect[$];
   burst_req_t   next_req;

   // local copy of the three class queues
   logic [TAG_W-1:0] class_slots [NUM_CLASSES][QUEUE_DEPTH];
   int unsigned      class_head  [NUM_CLASSES];
   int unsigned      class_fill  [NUM_CLASSES];

   int unsigned error_count;
   int unsigned served_seen;
   int unsigned cycle_count;
   int unsigned send_gap;
   int unsigned stall_left;
   bit          all_delivered;
   bit          tail_phase;
   bit          drain_pending;

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      reset                 = 1'b1;
      req_chan.valid        = 1'b0;
      req_chan.req_type     = REQ_ENQUEUE;
      req_chan.queue_class  = CLASS_FIRST;
      req_chan.customer_tag = '0;
      req_chan.serve_count  = '0;
      rsp_chan.ready        = 1'b0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
   end

   task automatic report_mismatch(input string what);
      begin
         $display("MISMATCH at result %0d: %s", served_seen, what);
         error_count++;
      end
   endtask

   task automatic add_req(input req_kind_type kind, input logic [CLASS_W-1:0] cls,
                          input logic [TAG_W-1:0] tag, input logic [SERVE_W-1:0] count);
      burst_req_t rq;
      begin
         rq.kind        = kind;
         rq.cls         = cls;
         rq.tag         = tag;
         rq.count       = count;
         rq.drain_first = drain_pending;
         drain_pending  = 1'b0;
         pending_reqs.push_back(rq);
      end
   endtask

   function automatic logic [TAG_W-1:0] rand_tag();
      return {$urandom, $urandom};
   endfunction

   // Advances the queue model by one accepted transaction and queues its served results.
   task automatic predict_burst(input burst_req_t rq);
      int           c;
      int unsigned  n;
      int unsigned  k;
      served_item_t s;
      begin
         c = (rq.cls == CLASS_OTHER) ? int'(CLASS_THIRD) : int'(rq.cls);
         if (rq.kind == REQ_ENQUEUE) begin
            if (class_fill[c] < QUEUE_DEPTH) begin
               class_slots[c][(class_head[c] + class_fill[c]) % QUEUE_DEPTH] = rq.tag;
               class_fill[c]++;
            end
         end else if (rq.cls != CLASS_OTHER) begin
            n = (rq.count > MAX_SERVE) ? MAX_SERVE : rq.count;
            for (k = 0; k < n; k++) begin
               s.cls = rq.cls;
               if (class_fill[c] == 0) begin
                  s.tag   = '0;
                  s.empty = 1'b1;
               end else begin
                  s.tag         = class_slots[c][class_head[c]];
                  s.empty       = 1'b0;
                  class_head[c] = (class_head[c] + 1) % QUEUE_DEPTH;
                  class_fill[c]--;
               end
               s.last = (k + 1 == n);
               served_expect.push_back(s);
            end
         end
      end
   endtask

   // stimulus
   initial begin
      int unsigned counted;
      int unsigned n;
      int unsigned i;
      int unsigned pick;
      logic [CLASS_W-1:0] cls;
      logic [CLASS_W-1:0] other_cls;
      bit          drain_done;

      error_count   = 0;
      served_seen   = 0;
      drain_pending = 1'b0;
      drain_done    = 1'b0;
      for (i = 0; i < NUM_CLASSES; i++) begin
         class_head[i] = 0;
         class_fill[i] = 0;
      end

      // directed: empty queue, unknown class, zero count, extreme tags, saturation
      add_req(REQ_SERVE,   CLASS_FIRST,  rand_tag(), 7'd1);
      add_req(REQ_SERVE,   CLASS_OTHER,  rand_tag(), 7'd5);
      add_req(REQ_SERVE,   CLASS_SECOND, rand_tag(), 7'd0);
      add_req(REQ_ENQUEUE, CLASS_FIRST,  {TAG_W{1'b1}}, 7'd127);
      add_req(REQ_ENQUEUE, CLASS_FIRST,  '0, 7'd0);
      add_req(REQ_ENQUEUE, CLASS_OTHER,  64'h0123_4567_89AB_CDEF, 7'd64);
      add_req(REQ_ENQUEUE, CLASS_THIRD,  64'h5555_5555_5555_5555, 7'd1);
      add_req(REQ_SERVE,   CLASS_FIRST,  rand_tag(), 7'd3);
      add_req(REQ_SERVE,   CLASS_THIRD,  rand_tag(), 7'd127);
      add_req(REQ_ENQUEUE, CLASS_SECOND, 64'hAAAA_AAAA_AAAA_AAAA, 7'd2);
      add_req(REQ_SERVE,   CLASS_SECOND, rand_tag(), 7'd64);
      add_req(REQ_ENQUEUE, CLASS_SECOND, 64'h4355_5354_4F4D_4552, 7'd0);
      add_req(REQ_SERVE,   CLASS_SECOND, rand_tag(), 7'd65);
      add_req(REQ_SERVE,   CLASS_FIRST,  rand_tag(), 7'd2);
      counted = 14;

      // full queue: overfill the second class, then drain it
      for (i = 0; i < 18; i++)
         add_req(REQ_ENQUEUE, CLASS_SECOND, rand_tag(), 7'($urandom_range(0, 127)));
      add_req(REQ_SERVE, CLASS_SECOND, rand_tag(), 7'd18);
      counted += 19;

      while (counted < REQ_TARGET) begin
         // halfway through, hold the sender once until every result is back
         if (!drain_done && counted >= REQ_TARGET / 2) begin
            drain_pending = 1'b1;
            drain_done    = 1'b1;
         end
         pick = $urandom_range(0, 9);
         cls  = 2'($urandom_range(0, 3));
         if (pick <= 4) begin
            // fill burst, usually followed by a serve of the same class
            n = $urandom_range(1, 20);
            for (i = 0; i < n; i++)
               add_req(REQ_ENQUEUE, cls, rand_tag(), 7'($urandom_range(0, 127)));
            counted += n;
            if ($urandom_range(0, 3) != 0) begin
               add_req(REQ_SERVE, (cls == CLASS_OTHER) ? CLASS_THIRD : cls, rand_tag(),
                       7'($urandom_range(1, n + 3)));
               counted++;
            end
         end else if (pick <= 7) begin
            cls = 2'($urandom_range(0, 2));
            if ($urandom_range(0, 5) == 0)
               add_req(REQ_SERVE, cls, rand_tag(), 7'($urandom_range(1, 127)));
            else
               add_req(REQ_SERVE, cls, rand_tag(), 7'($urandom_range(1, 8)));
            counted++;
         end else if (pick == 8) begin
            // ignored serves: unknown class or zero count
            if ($urandom_range(0, 1) == 0)
               add_req(REQ_SERVE, CLASS_OTHER, rand_tag(), 7'($urandom_range(0, 127)));
            else
               add_req(REQ_SERVE, 2'($urandom_range(0, 3)), rand_tag(), 7'd0);
            counted++;
         end else begin
            // broken sequence: enqueue one class, serve another
            other_cls = 2'(($urandom_range(1, 2) + ((cls == CLASS_OTHER) ? 2 : cls)) % 3);
            add_req(REQ_ENQUEUE, cls, rand_tag(), 7'($urandom_range(0, 127)));
            add_req(REQ_SERVE, other_cls, rand_tag(), 7'($urandom_range(1, 4)));
            counted += 2;
         end
      end

      do @(posedge clock); while (pending_reqs.size() != 0 || req_chan.valid);
      while (!all_delivered) @(posedge clock);
      repeat (SETTLE_CYC) @(posedge clock);
      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_chan.valid <= 1'b0;
         send_gap       <= 0;
         tail_phase     <= 1'b0;
      end else begin
         tail_phase <= (pending_reqs.size() < TAIL_ITEMS);
         if (!req_chan.valid || req_chan.ready) begin
            if (send_gap != 0) begin
               req_chan.valid <= 1'b0;
               send_gap       <= send_gap - 1;
            end else if (pending_reqs.size() == 0 ||
                         (pending_reqs[0].drain_first && (req_chan.valid || !all_delivered))) begin
               req_chan.valid <= 1'b0;
            end else begin
               next_req               = pending_reqs.pop_front();
               req_chan.valid        <= 1'b1;
               req_chan.req_type     <= next_req.kind;
               req_chan.queue_class  <= next_req.cls;
               req_chan.customer_tag <= next_req.tag;
               req_chan.serve_count  <= next_req.count;
               if (!tail_phase && $urandom_range(0, 4) == 0)
                  send_gap <= $urandom_range(1, 6);
            end
         end
      end
   end

   // response back-pressure
   always @(posedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
         stall_left     <= 0;
      end else if (stall_left != 0) begin
         rsp_chan.ready <= 1'b0;
         stall_left     <= stall_left - 1;
      end else if (!tail_phase && $urandom_range(0, 7) == 0) begin
         rsp_chan.ready <= 1'b0;
         stall_left     <= $urandom_range(0, 5);
      end else begin
         rsp_chan.ready <= 1'b1;
      end
   end

   // monitor: check served transactions, then predict from accepted requests
   always @(posedge clock) begin
      served_item_t want;
      burst_req_t   got_req;
      if (!reset) begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (served_expect.size() == 0) begin
               report_mismatch($sformatf("unexpected transaction class %0d tag %h",
                                         rsp_chan.served_class, rsp_chan.served_tag));
            end else begin
               want = served_expect.pop_front();
               if (rsp_chan.served_class !== want.cls)
                  report_mismatch($sformatf("served_class %0d, want %0d",
                                            rsp_chan.served_class, want.cls));
               if (rsp_chan.served_tag !== want.tag)
                  report_mismatch($sformatf("served_tag %h, want %h",
                                            rsp_chan.served_tag, want.tag));
               if (rsp_chan.was_empty !== want.empty)
                  report_mismatch($sformatf("was_empty %b, want %b",
                                            rsp_chan.was_empty, want.empty));
               if (rsp_chan.last_result !== want.last)
                  report_mismatch($sformatf("last_result %b, want %b",
                                            rsp_chan.last_result, want.last));
            end
            served_seen++;
         end
         if (req_chan.valid && req_chan.ready) begin
            got_req.kind        = req_kind_type'(req_chan.req_type);
            got_req.cls         = req_chan.queue_class;
            got_req.tag         = req_chan.customer_tag;
            got_req.count       = req_chan.serve_count;
            got_req.drain_first = 1'b0;
            predict_burst(got_req);
         end
      end
      all_delivered <= (served_expect.size() == 0);
   end

   always @(posedge clock) begin
      if (reset) begin
         cycle_count <= 0;
      end else begin
         cycle_count <= cycle_count + 1;
         if (cycle_count == CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
         end
      end
   end

endmodule

// ===== three_class_fifo_burst_server_unit.f =====
design/tcfbs_pkg.sv
design/tcfbs_if.sv
design/tcfbs_cell.sv
design/tcfbs_queue.sv
design/three_class_fifo_burst_server_unit.sv
design/tcfbs_checker.sv
tb/sv/tb_three_class_fifo_burst_server_unit.sv
